// ===== hdl/qres_pkg.sv =====
// Shared types, constants and saturating arithmetic helpers for the QR
// eigenvalue solver. Used by the controller, the datapath and the top level.
package qres_pkg;

  localparam int MAX_ORDER = 16;
  localparam int WORD_BITS = 64;
  localparam int FRAC_BITS = 32;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int SIZE_W    = 5;
  localparam int LIMIT_W   = 16;
  localparam int TOL_W     = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(16);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);
  localparam logic [TOL_W-1:0]   TOL_RESET   = TOL_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = CFG_IDX_W'(2);

  localparam logic [WORD_BITS-1:0] SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] SAT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    addr_t;

  typedef enum logic [1:0] {MUL_A_QA, MUL_A_RA, MUL_A_COEF} mul_a_e;
  typedef enum logic [1:0] {Q_SRC_W, Q_SRC_SUB, Q_SRC_DIV} q_src_e;
  typedef enum logic {W_SRC_IN, W_SRC_ACC} w_src_e;
  typedef enum logic {R_SRC_ACC, R_SRC_ROOT} r_src_e;
  typedef enum logic {COEF_ACC, COEF_ROOT} coef_src_e;

  typedef struct packed {
    logic      w_we;
    w_src_e    w_src;
    addr_t     w_waddr;
    addr_t     w_raddr;
    logic      q_we;
    q_src_e    q_src;
    addr_t     q_waddr;
    addr_t     q_raddr0;
    addr_t     q_raddr1;
    logic      r_we;
    r_src_e    r_src;
    addr_t     r_waddr;
    addr_t     r_raddr;
    logic      mul_start;
    mul_a_e    mul_a;
    logic      acc_clr;
    logic      acc_add;
    logic      coef_ld;
    coef_src_e coef_src;
    logic      sqrt_start;
    logic      div_start;
    logic      out_ld;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic root_big;
    logic acc_big;
  } sts_t;

  function automatic word_t mag(input word_t v);
    mag = v[WORD_BITS-1] ? (word_t'(0) - v) : v;
  endfunction

  function automatic word_t sat_mag(input logic neg, input word_t m, input logic ovf);
    word_t lim;
    word_t mm;
    lim = neg ? SAT_MIN : SAT_MAX;
    mm  = (ovf || (m > lim)) ? lim : m;
    sat_mag = neg ? (word_t'(0) - mm) : mm;
  endfunction

  function automatic word_t add_sat(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      add_sat = s[WORD_BITS] ? SAT_MIN : SAT_MAX;
    end else begin
      add_sat = s[WORD_BITS-1:0];
    end
  endfunction

  function automatic word_t sub_sat(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sub_sat = s[WORD_BITS] ? SAT_MIN : SAT_MAX;
    end else begin
      sub_sat = s[WORD_BITS-1:0];
    end
  endfunction

endpackage

// ===== hdl/qres_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module qres_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

// ===== hdl/qres_datapath.sv =====
// Datapath of the QR eigenvalue solver: matrix memories, multi-cycle multiplier,
// bit-serial divider and square root, accumulator. Depends on qres_pkg, qres_ram.
module qres_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  qres_pkg::cmd_t                 cmd_i,
  input  logic [qres_pkg::WORD_BITS-1:0] element_i,
  input  logic                           cfg_we_i,
  input  logic [qres_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qres_pkg::CFG_W-1:0]     cfg_data_i,
  output qres_pkg::sts_t                 sts_o,
  output logic [qres_pkg::WORD_BITS-1:0] eigenvalue_o
);
  import qres_pkg::*;

  localparam int HALF   = WORD_BITS / 2;
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int RAD_W  = WORD_BITS + FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int SREM_W = ROOT_W + 4;
  localparam int SCNT_W = $clog2(ROOT_W);
  localparam int DCNT_W = $clog2(RAD_W);

  word_t w_rd0, q_rd0, q_rd1, r_rd0;
  word_t w_wdata, q_wdata, r_wdata;
  word_t tol_q;
  word_t acc_q, coef_q, keep_q, eig_q;
  word_t prod, sub_res, div_res, root_ext, mul_a;

  // multiplier
  logic                 mul_busy_q, mul_done_q, mul_neg_q;
  logic [2:0]           mul_ph_q;
  word_t                mul_x_q, mul_y_q;
  logic [WORD_BITS-1:0] pp_q;
  logic [PROD_W-1:0]    sum_q, pp_sh;
  logic [HALF-1:0]      px, py;

  // square root
  logic                 sq_busy_q, sq_done_q;
  logic [SCNT_W-1:0]    sq_cnt_q;
  logic [RAD_W-1:0]     rad_q;
  logic [ROOT_W-1:0]    root_q;
  logic [SREM_W-1:0]    srem_q, srem_n, strial;

  // divider
  logic                 dv_busy_q, dv_done_q, dv_neg_q, dv_ovf_q;
  logic [DCNT_W-1:0]    dv_cnt_q;
  logic [RAD_W-1:0]     dvd_q;
  logic [WORD_BITS:0]   drem_q, drem_n;
  word_t                quo_q;

  qres_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_w_ram (
    .clk_i, .we_i(cmd_i.w_we), .waddr_i(cmd_i.w_waddr), .wdata_i(w_wdata),
    .raddr0_i(cmd_i.w_raddr), .raddr1_i(cmd_i.w_raddr),
    .rdata0_o(w_rd0), .rdata1_o()
  );

  qres_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_q_ram (
    .clk_i, .we_i(cmd_i.q_we), .waddr_i(cmd_i.q_waddr), .wdata_i(q_wdata),
    .raddr0_i(cmd_i.q_raddr0), .raddr1_i(cmd_i.q_raddr1),
    .rdata0_o(q_rd0), .rdata1_o(q_rd1)
  );

  qres_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_r_ram (
    .clk_i, .we_i(cmd_i.r_we), .waddr_i(cmd_i.r_waddr), .wdata_i(r_wdata),
    .raddr0_i(cmd_i.r_raddr), .raddr1_i(cmd_i.r_raddr),
    .rdata0_o(r_rd0), .rdata1_o()
  );

  assign prod     = sat_mag(mul_neg_q, sum_q[FRAC_BITS +: WORD_BITS],
                            |sum_q[PROD_W-1:FRAC_BITS+WORD_BITS]);
  assign sub_res  = sub_sat(keep_q, prod);
  assign div_res  = sat_mag(dv_neg_q, quo_q, dv_ovf_q);
  assign root_ext = WORD_BITS'(root_q);

  assign w_wdata = (cmd_i.w_src == W_SRC_IN) ? element_i : acc_q;
  assign r_wdata = (cmd_i.r_src == R_SRC_ROOT) ? root_ext : acc_q;

  always_comb begin
    unique case (cmd_i.q_src)
      Q_SRC_W:   q_wdata = w_rd0;
      Q_SRC_SUB: q_wdata = sub_res;
      Q_SRC_DIV: q_wdata = div_res;
      default:   q_wdata = w_rd0;
    endcase
  end

  always_comb begin
    unique case (cmd_i.mul_a)
      MUL_A_QA:   mul_a = q_rd0;
      MUL_A_RA:   mul_a = r_rd0;
      MUL_A_COEF: mul_a = coef_q;
      default:    mul_a = q_rd0;
    endcase
  end

  // partial product select and alignment
  always_comb begin
    unique case (mul_ph_q)
      3'd0:    begin px = mul_x_q[HALF-1:0];    py = mul_y_q[HALF-1:0];    end
      3'd1:    begin px = mul_x_q[HALF-1:0];    py = mul_y_q[WORD_BITS-1:HALF]; end
      3'd2:    begin px = mul_x_q[WORD_BITS-1:HALF]; py = mul_y_q[HALF-1:0]; end
      default: begin px = mul_x_q[WORD_BITS-1:HALF]; py = mul_y_q[WORD_BITS-1:HALF]; end
    endcase
    unique case (mul_ph_q)
      3'd1:      pp_sh = PROD_W'(pp_q);
      3'd2, 3'd3: pp_sh = PROD_W'(pp_q) << HALF;
      default:   pp_sh = PROD_W'(pp_q) << WORD_BITS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_done_q <= 1'b0;
      mul_ph_q   <= '0;
    end else if (cmd_i.mul_start) begin
      mul_busy_q <= 1'b1;
      mul_done_q <= 1'b0;
      mul_ph_q   <= '0;
    end else if (mul_busy_q) begin
      mul_ph_q <= mul_ph_q + 3'd1;
      if (mul_ph_q == 3'd4) begin
        mul_busy_q <= 1'b0;
        mul_done_q <= 1'b1;
      end
    end else begin
      mul_done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mul_x_q   <= mag(mul_a);
      mul_y_q   <= mag(q_rd1);
      mul_neg_q <= mul_a[WORD_BITS-1] ^ q_rd1[WORD_BITS-1];
      keep_q    <= q_rd0;
      sum_q     <= '0;
    end else if (mul_busy_q) begin
      if (mul_ph_q != 3'd4) begin
        pp_q <= px * py;
      end
      if (mul_ph_q != 3'd0) begin
        sum_q <= sum_q + pp_sh;
      end
    end
  end

  // square root, two radicand bits per cycle
  assign srem_n = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign strial = SREM_W'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_done_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (cmd_i.sqrt_start) begin
      sq_busy_q <= 1'b1;
      sq_done_q <= 1'b0;
      sq_cnt_q  <= SCNT_W'(ROOT_W - 1);
    end else if (sq_busy_q) begin
      sq_cnt_q <= sq_cnt_q - 1'b1;
      if (sq_cnt_q == '0) begin
        sq_busy_q <= 1'b0;
        sq_done_q <= 1'b1;
      end
    end else begin
      sq_done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      rad_q  <= {acc_q, {FRAC_BITS{1'b0}}};
      srem_q <= '0;
      root_q <= '0;
    end else if (sq_busy_q) begin
      rad_q <= rad_q << 2;
      if (srem_n >= strial) begin
        srem_q <= srem_n - strial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= srem_n;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  assign drem_n = {drem_q[WORD_BITS-1:0], dvd_q[RAD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_done_q <= 1'b0;
      dv_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      dv_busy_q <= 1'b1;
      dv_done_q <= 1'b0;
      dv_cnt_q  <= DCNT_W'(RAD_W - 1);
    end else if (dv_busy_q) begin
      dv_cnt_q <= dv_cnt_q - 1'b1;
      if (dv_cnt_q == '0) begin
        dv_busy_q <= 1'b0;
        dv_done_q <= 1'b1;
      end
    end else begin
      dv_done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q    <= {mag(q_rd0), {FRAC_BITS{1'b0}}};
      dv_neg_q <= q_rd0[WORD_BITS-1];
      dv_ovf_q <= 1'b0;
      drem_q   <= '0;
      quo_q    <= '0;
    end else if (dv_busy_q) begin
      dvd_q <= dvd_q << 1;
      if (quo_q[WORD_BITS-1]) begin
        dv_ovf_q <= 1'b1;
      end
      if (drem_n >= {1'b0, coef_q}) begin
        drem_q <= drem_n - {1'b0, coef_q};
        quo_q  <= {quo_q[WORD_BITS-2:0], 1'b1};
      end else begin
        drem_q <= drem_n;
        quo_q  <= {quo_q[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= add_sat(acc_q, prod);
    end
    if (cmd_i.coef_ld) begin
      coef_q <= (cmd_i.coef_src == COEF_ROOT) ? root_ext : acc_q;
    end
    if (cmd_i.out_ld) begin
      eig_q <= w_rd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= WORD_BITS'(TOL_RESET);
    end else if (cfg_we_i && (cfg_index_i == CFG_TOLERANCE)) begin
      tol_q <= WORD_BITS'(cfg_data_i[TOL_W-1:0]);
    end
  end

  assign sts_o.mul_done  = mul_done_q;
  assign sts_o.sqrt_done = sq_done_q;
  assign sts_o.div_done  = dv_done_q;
  assign sts_o.root_big  = root_ext > tol_q;
  assign sts_o.acc_big   = mag(acc_q) > tol_q;
  assign eigenvalue_o    = eig_q;

`ifndef SYNTHESIS
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_busy_q, sq_busy_q, dv_busy_q}))
    else $error("more than one arithmetic unit busy");
  a_mul_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul_start |=> mul_busy_q && !mul_done_q)
    else $error("multiplier did not start");
  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (coef_q != '0) && !coef_q[WORD_BITS-1])
    else $error("divider started with a non-positive divisor");
`endif

endmodule

// ===== hdl/qres_ctrl.sv =====
// Controller of the QR eigenvalue solver: load, Gram-Schmidt, R*Q, output
// sequencing. Depends on qres_pkg.
module qres_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [qres_pkg::IDX_W-1:0]     eigen_index_o,
  output logic                           converged_o,
  output logic                           last_result_o,
  input  logic                           cfg_we_i,
  input  logic [qres_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qres_pkg::CFG_W-1:0]     cfg_data_i,
  input  qres_pkg::sts_t                 sts_i,
  output qres_pkg::cmd_t                 cmd_o
);
  import qres_pkg::*;

  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_CP_RD    = 5'd1;
  localparam logic [4:0] S_CP_WR    = 5'd2;
  localparam logic [4:0] S_PJ_INIT  = 5'd3;
  localparam logic [4:0] S_PJ_RD    = 5'd4;
  localparam logic [4:0] S_PJ_MUL   = 5'd5;
  localparam logic [4:0] S_PJ_WAIT  = 5'd6;
  localparam logic [4:0] S_PJ_STORE = 5'd7;
  localparam logic [4:0] S_UP_RD    = 5'd8;
  localparam logic [4:0] S_UP_MUL   = 5'd9;
  localparam logic [4:0] S_UP_WAIT  = 5'd10;
  localparam logic [4:0] S_NRM_INIT = 5'd11;
  localparam logic [4:0] S_NRM_RD   = 5'd12;
  localparam logic [4:0] S_NRM_MUL  = 5'd13;
  localparam logic [4:0] S_NRM_WAIT = 5'd14;
  localparam logic [4:0] S_SQ_START = 5'd15;
  localparam logic [4:0] S_SQ_WAIT  = 5'd16;
  localparam logic [4:0] S_DV_RD    = 5'd17;
  localparam logic [4:0] S_DV_START = 5'd18;
  localparam logic [4:0] S_DV_WAIT  = 5'd19;
  localparam logic [4:0] S_K_NEXT   = 5'd20;
  localparam logic [4:0] S_RC_INIT  = 5'd21;
  localparam logic [4:0] S_RC_RD    = 5'd22;
  localparam logic [4:0] S_RC_MUL   = 5'd23;
  localparam logic [4:0] S_RC_WAIT  = 5'd24;
  localparam logic [4:0] S_RC_STORE = 5'd25;
  localparam logic [4:0] S_IT_END   = 5'd26;
  localparam logic [4:0] S_OUT_RD   = 5'd27;
  localparam logic [4:0] S_OUT_LD   = 5'd28;
  localparam logic [4:0] S_OUT_WAIT = 5'd29;

  logic [4:0]         state_q, state_d;
  logic [IDX_W-1:0]   i_q, i_d, j_q, j_d, k_q, k_d, idx_q, idx_d;
  logic [LIMIT_W-1:0] iter_q, iter_d, limit_q, limit_d;
  logic [SIZE_W-1:0]  size_q, size_d, ord;
  logic [IDX_W-1:0]   nm1;
  logic               conv_q, conv_d, small_q, small_d;
  logic               ovalid_q, ovalid_d, last_q, last_d;
  logic               in_acc;

  always_comb begin
    if (size_q == '0) begin
      ord = SIZE_W'(1);
    end else if (size_q > SIZE_W'(MAX_ORDER)) begin
      ord = SIZE_W'(MAX_ORDER);
    end else begin
      ord = size_q;
    end
  end
  assign nm1    = IDX_W'(ord - SIZE_W'(1));
  assign in_acc = in_valid_i && (state_q == S_LOAD);

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    k_d      = k_q;
    idx_d    = idx_q;
    iter_d   = iter_q;
    limit_d  = limit_q;
    size_d   = size_q;
    conv_d   = conv_q;
    small_d  = small_q;
    ovalid_d = ovalid_q;
    last_d   = last_q;
    cmd_o    = '0;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cmd_o.w_we    = 1'b1;
          cmd_o.w_src   = W_SRC_IN;
          cmd_o.w_waddr = {i_q, j_q};
          if (j_q == nm1) begin
            j_d = '0;
            if (i_q == nm1) begin
              i_d    = '0;
              k_d    = '0;
              iter_d = '0;
              conv_d = 1'b0;
              state_d = (limit_q == '0) ? S_OUT_RD : S_CP_RD;
            end else begin
              i_d = i_q + 1'b1;
            end
          end else begin
            j_d = j_q + 1'b1;
          end
        end
      end
      S_CP_RD: begin
        cmd_o.w_raddr = {i_q, k_q};
        state_d = S_CP_WR;
      end
      S_CP_WR: begin
        cmd_o.q_we    = 1'b1;
        cmd_o.q_src   = Q_SRC_W;
        cmd_o.q_waddr = {i_q, k_q};
        if (i_q == nm1) begin
          i_d = '0;
          j_d = '0;
          state_d = (k_q == '0) ? S_NRM_INIT : S_PJ_INIT;
        end else begin
          i_d = i_q + 1'b1;
          state_d = S_CP_RD;
        end
      end
      S_PJ_INIT: begin
        cmd_o.acc_clr = 1'b1;
        i_d = '0;
        state_d = S_PJ_RD;
      end
      S_PJ_RD: begin
        cmd_o.q_raddr0 = {i_q, j_q};
        cmd_o.q_raddr1 = {i_q, k_q};
        state_d = S_PJ_MUL;
      end
      S_PJ_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_a     = MUL_A_QA;
        state_d = S_PJ_WAIT;
      end
      S_PJ_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_add = 1'b1;
          if (i_q == nm1) begin
            state_d = S_PJ_STORE;
          end else begin
            i_d = i_q + 1'b1;
            state_d = S_PJ_RD;
          end
        end
      end
      S_PJ_STORE: begin
        cmd_o.r_we     = 1'b1;
        cmd_o.r_src    = R_SRC_ACC;
        cmd_o.r_waddr  = {j_q, k_q};
        cmd_o.coef_ld  = 1'b1;
        cmd_o.coef_src = COEF_ACC;
        i_d = '0;
        state_d = S_UP_RD;
      end
      S_UP_RD: begin
        cmd_o.q_raddr0 = {i_q, k_q};
        cmd_o.q_raddr1 = {i_q, j_q};
        state_d = S_UP_MUL;
      end
      S_UP_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_a     = MUL_A_COEF;
        state_d = S_UP_WAIT;
      end
      S_UP_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.q_we    = 1'b1;
          cmd_o.q_src   = Q_SRC_SUB;
          cmd_o.q_waddr = {i_q, k_q};
          if (i_q == nm1) begin
            i_d = '0;
            if (j_q == k_q - 1'b1) begin
              state_d = S_NRM_INIT;
            end else begin
              j_d = j_q + 1'b1;
              state_d = S_PJ_INIT;
            end
          end else begin
            i_d = i_q + 1'b1;
            state_d = S_UP_RD;
          end
        end
      end
      S_NRM_INIT: begin
        cmd_o.acc_clr = 1'b1;
        i_d = '0;
        state_d = S_NRM_RD;
      end
      S_NRM_RD: begin
        cmd_o.q_raddr0 = {i_q, k_q};
        cmd_o.q_raddr1 = {i_q, k_q};
        state_d = S_NRM_MUL;
      end
      S_NRM_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_a     = MUL_A_QA;
        state_d = S_NRM_WAIT;
      end
      S_NRM_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_add = 1'b1;
          if (i_q == nm1) begin
            state_d = S_SQ_START;
          end else begin
            i_d = i_q + 1'b1;
            state_d = S_NRM_RD;
          end
        end
      end
      S_SQ_START: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (sts_i.sqrt_done) begin
          cmd_o.r_we     = 1'b1;
          cmd_o.r_src    = R_SRC_ROOT;
          cmd_o.r_waddr  = {k_q, k_q};
          cmd_o.coef_ld  = 1'b1;
          cmd_o.coef_src = COEF_ROOT;
          i_d = '0;
          state_d = sts_i.root_big ? S_DV_RD : S_K_NEXT;
        end
      end
      S_DV_RD: begin
        cmd_o.q_raddr0 = {i_q, k_q};
        state_d = S_DV_START;
      end
      S_DV_START: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DV_WAIT;
      end
      S_DV_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.q_we    = 1'b1;
          cmd_o.q_src   = Q_SRC_DIV;
          cmd_o.q_waddr = {i_q, k_q};
          if (i_q == nm1) begin
            state_d = S_K_NEXT;
          end else begin
            i_d = i_q + 1'b1;
            state_d = S_DV_RD;
          end
        end
      end
      S_K_NEXT: begin
        i_d = '0;
        j_d = '0;
        if (k_q == nm1) begin
          small_d = 1'b1;
          state_d = S_RC_INIT;
        end else begin
          k_d = k_q + 1'b1;
          state_d = S_CP_RD;
        end
      end
      S_RC_INIT: begin
        cmd_o.acc_clr = 1'b1;
        k_d = i_q;
        state_d = S_RC_RD;
      end
      S_RC_RD: begin
        cmd_o.r_raddr  = {i_q, k_q};
        cmd_o.q_raddr1 = {k_q, j_q};
        state_d = S_RC_MUL;
      end
      S_RC_MUL: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_a     = MUL_A_RA;
        state_d = S_RC_WAIT;
      end
      S_RC_WAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.acc_add = 1'b1;
          if (k_q == nm1) begin
            state_d = S_RC_STORE;
          end else begin
            k_d = k_q + 1'b1;
            state_d = S_RC_RD;
          end
        end
      end
      S_RC_STORE: begin
        cmd_o.w_we    = 1'b1;
        cmd_o.w_src   = W_SRC_ACC;
        cmd_o.w_waddr = {i_q, j_q};
        if ((i_q != j_q) && sts_i.acc_big) begin
          small_d = 1'b0;
        end
        state_d = S_RC_INIT;
        if (j_q == nm1) begin
          j_d = '0;
          if (i_q == nm1) begin
            state_d = S_IT_END;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_IT_END: begin
        iter_d = iter_q + 1'b1;
        i_d = '0;
        k_d = '0;
        if (small_q) begin
          conv_d  = 1'b1;
          state_d = S_OUT_RD;
        end else if ((iter_q + 1'b1) >= limit_q) begin
          state_d = S_OUT_RD;
        end else begin
          state_d = S_CP_RD;
        end
      end
      S_OUT_RD: begin
        cmd_o.w_raddr = {i_q, i_q};
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        cmd_o.out_ld = 1'b1;
        ovalid_d = 1'b1;
        idx_d    = i_q;
        last_d   = (i_q == nm1);
        state_d  = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready_i) begin
          ovalid_d = 1'b0;
          if (last_q) begin
            i_d = '0;
            j_d = '0;
            state_d = S_LOAD;
          end else begin
            i_d = i_q + 1'b1;
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase

    if (cfg_we_i) begin
      priority if (cfg_index_i == CFG_MATRIX_SIZE) begin
        size_d = cfg_data_i[SIZE_W-1:0];
        i_d    = '0;
        j_d    = '0;
      end else if (cfg_index_i == CFG_ITER_LIMIT) begin
        limit_d = cfg_data_i[LIMIT_W-1:0];
      end else begin
        size_d = size_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      idx_q    <= '0;
      iter_q   <= '0;
      limit_q  <= LIMIT_RESET;
      size_q   <= SIZE_RESET;
      conv_q   <= 1'b0;
      small_q  <= 1'b0;
      ovalid_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      idx_q    <= idx_d;
      iter_q   <= iter_d;
      limit_q  <= limit_d;
      size_q   <= size_d;
      conv_q   <= conv_d;
      small_q  <= small_d;
      ovalid_q <= ovalid_d;
      last_q   <= last_d;
    end
  end

  assign in_ready_o    = (state_q == S_LOAD);
  assign out_valid_o   = ovalid_q;
  assign eigen_index_o = idx_q;
  assign converged_o   = conv_q;
  assign last_result_o = last_q;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_result_o) |-> (eigen_index_o == nm1))
    else $error("last result on the wrong row");
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IT_END) |-> (iter_q < limit_q))
    else $error("iteration count past the limit");
`endif

endmodule

// ===== hdl/qr_eigenvalue_solver.sv =====
// Top level of the QR eigenvalue solver: controller plus datapath.
// Depends on qres_pkg, qres_ctrl, qres_datapath (and qres_ram below it).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, element_i): n*n Q31.32 elements in
//   row-major order, one transaction per cycle while loading.
//   After the last element the block runs unshifted QR iterations; input
//   ready stays low until every result has been taken.
//   Output channel (out_valid_o/out_ready_i): n transactions, one per row,
//   carrying the diagonal entry, its index, the converged flag and a last
//   marker on row n-1. A result holds until out_ready_i; out_valid_o drops
//   between rows while the next diagonal entry is read and loaded.
//   Per iteration: about 3*n^3/2 products of multiply-accumulate, each on
//   one 32x32 multiplier over four partial products, plus a square root
//   and, when the root exceeds the tolerance, n divisions per column; the
//   iteration count runs up to iteration_limit.
//   Configuration (cfg_we_i, cfg_index_i, cfg_data_i): 0 matrix_size,
//   1 iteration_limit, 2 tolerance; writing matrix_size restarts loading.
//   Reset: size 16, limit 1000, tolerance 1, load position zero; matrix
//   memories are not cleared.
module qr_eigenvalue_solver
  import qres_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [qres_pkg::WORD_BITS-1:0] element_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [qres_pkg::WORD_BITS-1:0] eigenvalue_o,
  output logic [qres_pkg::IDX_W-1:0]     eigen_index_o,
  output logic                           converged_o,
  output logic                           last_result_o,
  input  logic                           cfg_we_i,
  input  logic [qres_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qres_pkg::CFG_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  qres_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .out_valid_o, .out_ready_i,
    .eigen_index_o, .converged_o, .last_result_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  qres_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .element_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .sts_o(sts), .eigenvalue_o
  );

endmodule

// ===== bench/tb_qr_eigenvalue_solver.sv =====
// Testbench for qr_eigenvalue_solver: loads matrices, predicts the QR diagonal
// in Q31.32 and checks every result transaction against the prediction.
// Depends on qres_pkg and the qr_eigenvalue_solver RTL.
module tb_qr_eigenvalue_solver;
  import qres_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int HOLD_CYCLES    = 600;
  localparam int TARGET_ITEMS   = 160;

  typedef struct {
    word_t      val;
    logic [3:0] idx;
    logic       conv;
    logic       last;
  } eig_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  word_t element_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  word_t eigenvalue_o;
  logic [IDX_W-1:0] eigen_index_o;
  logic converged_o;
  logic last_result_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_MATRIX_SIZE;
  logic [CFG_W-1:0] cfg_data_i = '0;

  word_t work_m[DEPTH];
  word_t q_m[DEPTH];
  word_t r_m[DEPTH];
  int unsigned fill_cnt = 0;
  int unsigned ord_cfg = 16;
  int unsigned iter_cap = 1000;
  word_t tol = 64'd1;

  word_t item_q[$];
  eig_t eig_q[$];
  int err_cnt = 0;
  int quiet_cnt = 0;
  int hold_cnt = 0;
  bit stall_req = 1'b0;
  bit no_gap = 1'b0;
  logic holding;

  qr_eigenvalue_solver dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic word_t absval(word_t v);
    return v[63] ? -v : v;
  endfunction

  function automatic word_t sat_signed(logic neg, word_t m, logic ovf);
    word_t lim;
    lim = neg ? SAT_MIN : SAT_MAX;
    if (ovf || m > lim) m = lim;
    return neg ? -m : m;
  endfunction

  function automatic word_t sum_sat(word_t a, word_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
    return s[63:0];
  endfunction

  function automatic word_t diff_sat(word_t a, word_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
    return s[63:0];
  endfunction

  function automatic word_t fx_mul(word_t a, word_t b);
    logic [127:0] p;
    p = {64'd0, absval(a)} * {64'd0, absval(b)};
    return sat_signed(a[63] ^ b[63], p[95:32], p[127:96] != 0);
  endfunction

  function automatic word_t fx_div(word_t a, word_t d);
    logic [95:0] q;
    q = {absval(a), 32'd0} / {32'd0, d};
    return sat_signed(a[63], q[63:0], q[95:64] != 0);
  endfunction

  function automatic word_t fx_sqrt(word_t s);
    logic [95:0] v;
    logic [95:0] root;
    logic [95:0] cand;
    v = {s, 32'd0};
    root = '0;
    for (int b = 47; b >= 0; b--) begin
      cand = root | (96'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root[63:0];
  endfunction

  function automatic void qr_factor(int n);
    word_t acc;
    word_t d;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) q_m[i*n+k] = work_m[i*n+k];
      for (int j = 0; j < k; j++) begin
        acc = '0;
        for (int i = 0; i < n; i++) acc = sum_sat(acc, fx_mul(q_m[i*n+j], q_m[i*n+k]));
        r_m[j*n+k] = acc;
        for (int i = 0; i < n; i++) q_m[i*n+k] = diff_sat(q_m[i*n+k], fx_mul(acc, q_m[i*n+j]));
      end
      for (int j = k + 1; j < n; j++) r_m[j*n+k] = '0;
      acc = '0;
      for (int i = 0; i < n; i++) acc = sum_sat(acc, fx_mul(q_m[i*n+k], q_m[i*n+k]));
      d = fx_sqrt(acc);
      r_m[k*n+k] = d;
      if (d > tol) begin
        for (int i = 0; i < n; i++) q_m[i*n+k] = fx_div(q_m[i*n+k], d);
      end
    end
  endfunction

  function automatic void qr_remix(int n);
    word_t acc;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) acc = sum_sat(acc, fx_mul(r_m[i*n+k], q_m[k*n+j]));
        work_m[i*n+j] = acc;
      end
    end
  endfunction

  function automatic bit offdiag_settled(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (i != j && absval(work_m[i*n+j]) > tol) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void absorb_element(word_t e);
    int n;
    bit conv;
    eig_t r;
    n = (ord_cfg == 0) ? 1 : (ord_cfg > MAX_ORDER) ? MAX_ORDER : ord_cfg;
    conv = 1'b0;
    work_m[fill_cnt % DEPTH] = e;
    fill_cnt++;
    if (fill_cnt < n * n) return;
    fill_cnt = 0;
    for (int it = 0; it < iter_cap; it++) begin
      qr_factor(n);
      qr_remix(n);
      if (offdiag_settled(n)) begin
        conv = 1'b1;
        break;
      end
    end
    for (int i = 0; i < n; i++) begin
      r.val = work_m[i*n+i];
      r.idx = 4'(i);
      r.conv = conv;
      r.last = (i == n - 1);
      eig_q.push_back(r);
    end
  endfunction

  task automatic report(string what, word_t got, word_t want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      element_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) absorb_element(element_i);
      if (item_q.size() > 0 && (no_gap || $urandom_range(0, 99) >= 16)) begin
        element_i <= item_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  assign holding = stall_req && hold_cnt < HOLD_CYCLES;

  always @(posedge clk_i) begin
    if (holding) hold_cnt <= hold_cnt + 1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    eig_t w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (eig_q.size() == 0) begin
          report("unexpected result", eigenvalue_o, '0);
        end else begin
          w = eig_q.pop_front();
          if (eigenvalue_o !== w.val) report("eigenvalue", eigenvalue_o, w.val);
          if (eigen_index_o !== w.idx) report("eigen_index", 64'(eigen_index_o), 64'(w.idx));
          if (converged_o !== w.conv) report("converged", 64'(converged_o), 64'(w.conv));
          if (last_result_o !== w.last) report("last_result", 64'(last_result_o), 64'(w.last));
        end
      end
      out_ready_i <= !holding && (no_gap || $urandom_range(0, 99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("qr_eigenvalue_solver test failed");
      $finish;
    end
  end

  task automatic settle();
    wait (item_q.size() == 0 && !in_valid_i && eig_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_MATRIX_SIZE: begin
        ord_cfg = data & 32'h1F;
        fill_cnt = 0;
      end
      CFG_ITER_LIMIT: iter_cap = data & 32'hFFFF;
      CFG_TOLERANCE: tol = {32'd0, data};
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic word_t pick_value(int kind);
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    case (kind)
      0: return v >>> $urandom_range(26, 60);
      1: return v;
      default: return $urandom_range(0, 1) ? SAT_MAX : SAT_MIN;
    endcase
  endfunction

  // shape 0 dense, 1 diagonal, 2 upper triangular, 3 wide range
  task automatic load_matrix(int n, int shape, int cnt);
    word_t v;
    for (int e = 0; e < cnt; e++) begin
      v = pick_value(shape == 3 ? $urandom_range(0, 2) : 0);
      if (shape == 1 && e / n != e % n) v = '0;
      if (shape == 2 && e / n > e % n) v = '0;
      item_q.push_back(v);
    end
  endtask

  initial begin
    int sent;
    int n;
    int shape;
    int cut;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_reg(CFG_MATRIX_SIZE, 32'd1);
    set_reg(CFG_ITER_LIMIT, 32'hFFFF);
    set_reg(CFG_TOLERANCE, 32'd0);
    item_q.push_back(SAT_MIN);
    settle();
    set_reg(CFG_MATRIX_SIZE, 32'd0);
    item_q.push_back(SAT_MAX);
    settle();
    set_reg(CFG_MATRIX_SIZE, 32'd2);
    set_reg(CFG_ITER_LIMIT, 32'd0);
    item_q.push_back(SAT_MAX);
    item_q.push_back(64'h0000_0001_0000_0000);
    item_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    item_q.push_back(SAT_MIN);
    settle();
    set_reg(CFG_ITER_LIMIT, 32'd3);
    set_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
    load_matrix(2, 0, 4);
    settle();
    set_reg(CFG_TOLERANCE, 32'd1000);
    item_q.push_back(64'h0000_0002_0000_0000);
    item_q.push_back('0);
    item_q.push_back(64'h0000_0000_8000_0000);
    item_q.push_back('0);
    settle();
    set_reg(CFG_MATRIX_SIZE, 32'd3);
    set_reg(CFG_ITER_LIMIT, 32'd4);
    set_reg(CFG_TOLERANCE, 32'd1);
    load_matrix(3, 0, 4);
    settle();
    set_reg(CFG_MATRIX_SIZE, 32'd2);
    load_matrix(2, 3, 4);
    settle();

    sent = 0;
    while (sent < TARGET_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 5) : $urandom_range(1, 3);
      shape = $urandom_range(0, 3);
      set_reg(CFG_MATRIX_SIZE, 32'(n));
      set_reg(CFG_ITER_LIMIT, 32'($urandom_range(0, 11) == 0 ? 0 : $urandom_range(1, 10)));
      case ($urandom_range(0, 3))
        0: set_reg(CFG_TOLERANCE, 32'd0);
        1: set_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
        2: set_reg(CFG_TOLERANCE, $urandom_range(0, 1 << 20));
        default: set_reg(CFG_TOLERANCE, $urandom);
      endcase
      if (n > 1 && $urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, n * n - 1);
        load_matrix(n, shape, cut);
        settle();
        set_reg(CFG_MATRIX_SIZE, 32'(n));
      end
      no_gap = (sent >= 60 && sent < 100);
      if (sent >= 20 && !stall_req) stall_req = 1'b1;
      load_matrix(n, shape, n * n);
      if ($urandom_range(0, 1)) load_matrix(n, shape, n * n);
      sent += item_q.size();
      settle();
    end

    wait (item_q.size() == 0 && !in_valid_i && eig_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("qr_eigenvalue_solver test passed");
    end else begin
      $display("qr_eigenvalue_solver test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qres_pkg.sv
hdl/qres_ram.sv
hdl/qres_datapath.sv
hdl/qres_ctrl.sv
hdl/qr_eigenvalue_solver.sv
bench/tb_qr_eigenvalue_solver.sv
